// File: rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// Batch sort statistics package
// Field widths and default sizing shared by the interfaces and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bss_pkg;

  localparam int DEF_MAX_SET_SIZE = 32;
  localparam int SAMPLE_W         = 8;
  localparam int MEAN_W           = 16;
  localparam int SIZE_W           = 6;

endpackage

// File: rtl/bss_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Carries one unsigned byte per beat, with a flag on the last byte of a set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bss_in_if;

  logic                         valid;
  logic                         ready;
  logic [bss_pkg::SAMPLE_W-1:0] sample;
  logic                         final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);

endinterface

// File: rtl/bss_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one sorted value per beat together with the statistics of its set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bss_out_if;

  logic                         valid;
  logic                         ready;
  logic [bss_pkg::SAMPLE_W-1:0] sorted_value;
  logic [bss_pkg::MEAN_W-1:0]   mean_fixed;
  logic [bss_pkg::SAMPLE_W-1:0] median_value;
  logic [bss_pkg::SAMPLE_W-1:0] maximum_value;
  logic [bss_pkg::SAMPLE_W-1:0] minimum_value;
  logic [bss_pkg::SIZE_W-1:0]   set_size;
  logic                         overflow_flag;
  logic                         final_result;

  modport source (
    output valid, output sorted_value, output mean_fixed, output median_value,
    output maximum_value, output minimum_value, output set_size,
    output overflow_flag, output final_result, input ready
  );
  modport sink (
    input valid, input sorted_value, input mean_fixed, input median_value,
    input maximum_value, input minimum_value, input set_size,
    input overflow_flag, input final_result, output ready
  );

endinterface

// File: rtl/batch_sort_statistics.sv
// ----------------------------------------------------------------------------
// Batch sort statistics
// Collects bytes into a set, sorts it in descending order in a memory with one
// read and one write port and emits each value with the mean, median, maximum
// and minimum.
// Loading accepts one sample beat per cycle; samples past capacity are dropped.
// After the closing beat, an in-place exchange sort with one comparator orders
// a set of n > 1, then a bit-serial divider forms the mean of the set and the
// maximum, minimum and median are read back from the memory.
// Results leave one beat at a time, each held while the sink is not ready;
// loading resumes once the last beat of the set is issued.
// Reset clears the fill count, sum, drop flag and state; the memory is not.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module batch_sort_statistics #(
  parameter int MAX_SET_SIZE = bss_pkg::DEF_MAX_SET_SIZE
) (
  input  logic      clk,
  input  logic      rst,
  bss_in_if.sink    samples,
  bss_out_if.source results
);

  import bss_pkg::*;

  localparam int CW   = $clog2(MAX_SET_SIZE + 1);
  localparam int AW   = $clog2(MAX_SET_SIZE);
  localparam int SUMW = $clog2(255 * MAX_SET_SIZE + 1);
  localparam int DW   = SUMW + 8;
  localparam int DCW  = $clog2(DW);

  typedef enum logic [3:0] {
    S_LOAD, S_SORT_A, S_CUR, S_CMP, S_WB, S_DIV,
    S_ST1, S_ST2, S_ST3, S_ST4, S_EMIT_RD, S_EMIT_SHOW
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] mem [MAX_SET_SIZE];
  logic [SAMPLE_W-1:0] rdata;

  logic [CW-1:0]       count;
  logic [SUMW-1:0]     sum;
  logic                dropped;
  logic [AW-1:0]       a;
  logic [AW-1:0]       b;
  logic [AW-1:0]       k;
  logic [SAMPLE_W-1:0] cur;
  logic [SAMPLE_W-1:0] mid_hi;
  logic [SAMPLE_W-1:0] max_v;
  logic [SAMPLE_W-1:0] min_v;
  logic [SAMPLE_W-1:0] med_v;
  logic [DW-1:0]       dvd;
  logic [CW-1:0]       rem;
  logic [DCW-1:0]      div_cnt;

  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;

  logic                full;
  logic [CW-1:0]       count_next;
  logic [SUMW-1:0]     sum_next;
  logic [CW-1:0]       cnt_m1;
  logic [CW-1:0]       cnt_m2;
  logic [CW-1:0]       cnt_half;
  logic [CW-1:0]       cnt_half_m1;
  logic [AW-1:0]       nm1;
  logic [AW-1:0]       nm2;
  logic [CW:0]         rem_shift;
  logic [CW:0]         rem_sub;
  logic                rem_ge;
  logic [SAMPLE_W:0]   med_sum;

  assign full        = (count == CW'(MAX_SET_SIZE));
  assign count_next  = full ? count : count + CW'(1);
  assign sum_next    = full ? sum : sum + SUMW'(samples.sample);
  assign cnt_m1      = count - CW'(1);
  assign cnt_m2      = count - CW'(2);
  assign cnt_half    = count >> 1;
  assign cnt_half_m1 = cnt_half - CW'(1);
  assign nm1         = cnt_m1[AW-1:0];
  assign nm2         = cnt_m2[AW-1:0];
  assign rem_shift   = {rem, dvd[DW-1]};
  assign rem_sub     = rem_shift - {1'b0, count};
  assign rem_ge      = (rem_shift >= {1'b0, count});
  assign med_sum     = {1'b0, mid_hi} + {1'b0, rdata};

  assign samples.ready = (state == S_LOAD);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = a;
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = samples.sample;
    case (state)
      S_LOAD: begin
        wr_en = samples.valid && !full;
      end
      S_SORT_A: begin
        rd_en = 1'b1;
      end
      S_CUR: begin
        rd_en   = 1'b1;
        rd_addr = a + AW'(1);
      end
      S_CMP: begin
        if (rdata > cur) begin
          wr_en   = 1'b1;
          wr_addr = b;
          wr_data = cur;
        end
        if (b != nm1) begin
          rd_en   = 1'b1;
          rd_addr = b + AW'(1);
        end
      end
      S_WB: begin
        wr_en   = 1'b1;
        wr_addr = a;
        wr_data = cur;
        if (a != nm2) begin
          rd_en   = 1'b1;
          rd_addr = a + AW'(1);
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_ST1: begin
        rd_en   = 1'b1;
        rd_addr = nm1;
      end
      S_ST2: begin
        rd_en   = 1'b1;
        rd_addr = cnt_half[AW-1:0];
      end
      S_ST3: begin
        if (!count[0]) begin
          rd_en   = 1'b1;
          rd_addr = cnt_half_m1[AW-1:0];
        end
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      sum           <= '0;
      dropped       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_EMIT_SHOW) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (samples.valid) begin
            count <= count_next;
            sum   <= sum_next;
            if (full) begin
              dropped <= 1'b1;
            end
            if (samples.final_sample) begin
              a       <= '0;
              dvd     <= {sum_next, 8'h00};
              rem     <= '0;
              div_cnt <= DCW'(DW - 1);
              state   <= (count_next > CW'(1)) ? S_SORT_A : S_DIV;
            end
          end
        end
        S_SORT_A: begin
          state <= S_CUR;
        end
        S_CUR: begin
          cur   <= rdata;
          b     <= a + AW'(1);
          state <= S_CMP;
        end
        S_CMP: begin
          if (rdata > cur) begin
            cur <= rdata;
          end
          if (b == nm1) begin
            state <= S_WB;
          end else begin
            b <= b + AW'(1);
          end
        end
        S_WB: begin
          if (a == nm2) begin
            state <= S_DIV;
          end else begin
            a     <= a + AW'(1);
            state <= S_CUR;
          end
        end
        S_DIV: begin
          dvd <= {dvd[DW-2:0], rem_ge};
          rem <= rem_ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
          if (div_cnt == '0) begin
            state <= S_ST1;
          end else begin
            div_cnt <= div_cnt - DCW'(1);
          end
        end
        S_ST1: begin
          max_v <= rdata;
          state <= S_ST2;
        end
        S_ST2: begin
          min_v <= rdata;
          state <= S_ST3;
        end
        S_ST3: begin
          if (count[0]) begin
            med_v <= rdata;
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            mid_hi <= rdata;
            state  <= S_ST4;
          end
        end
        S_ST4: begin
          med_v <= med_sum[SAMPLE_W:1];
          k     <= '0;
          state <= S_EMIT_RD;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_SHOW;
        end
        S_EMIT_SHOW: begin
          if (!results.valid || results.ready) begin
            results.valid         <= 1'b1;
            results.sorted_value  <= rdata;
            results.mean_fixed    <= dvd[MEAN_W-1:0];
            results.median_value  <= med_v;
            results.maximum_value <= max_v;
            results.minimum_value <= min_v;
            results.set_size      <= SIZE_W'(count);
            results.overflow_flag <= dropped;
            results.final_result  <= (k == nm1);
            if (k == nm1) begin
              count   <= '0;
              sum     <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k + AW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SET_SIZE))
    else $error("fill count exceeds capacity");

  a_value_in_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.sorted_value <= results.maximum_value) &&
                      (results.sorted_value >= results.minimum_value))
    else $error("sorted value outside minimum and maximum");

  a_last_is_min: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.final_result |->
      results.sorted_value == results.minimum_value)
    else $error("last beat of a set is not its minimum");

  a_stats_order: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.mean_fixed <= {results.maximum_value, 8'h00}) &&
                      (results.median_value <= results.maximum_value) &&
                      (results.median_value >= results.minimum_value))
    else $error("mean or median outside the range of the set");
`endif

endmodule
